[rtl/gcvbs_pkg.sv]
`timescale 1ns / 1ps
// gcvbs_pkg: shared types and constants for the GC victim block selector.
// No dependencies; imported by gcvbs_pick and gc_victim_block_selector.
package gcvbs_pkg;

    localparam int NUM_BLOCKS = 256;
    localparam int BLK_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = 11;
    localparam int STAMP_W    = 48;
    localparam int ERASE_W    = 32;

    localparam logic [BLK_W-1:0]   LAST_BLOCK      = BLK_W'(NUM_BLOCKS - 1);
    localparam logic [STAMP_W-1:0] FIFO_TIME_LIMIT = 48'd10000000000000;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_ERASE  = 2'd1;
    localparam logic [1:0] OP_SELECT = 2'd2;

    localparam logic CFG_POLICY_MODE     = 1'b0;
    localparam logic CFG_PAGES_PER_BLOCK = 1'b1;

    localparam logic POLICY_GREEDY = 1'b0;

    typedef struct packed {
        logic [1:0]         op;
        logic [7:0]         block_index;
        logic [CNT_W-1:0]   free_count_in;
        logic [CNT_W-1:0]   invalid_count_in;
        logic [STAMP_W-1:0] write_time_in;
        logic [7:0]         hot_active_block;
        logic [7:0]         cold_active_block_in;
    } req_t;

    typedef struct packed {
        logic [7:0]         victim_block;
        logic               status;
        logic [ERASE_W-1:0] erase_total;
    } rsp_t;

    typedef struct packed {
        logic [CNT_W-1:0]   free_pages;
        logic [CNT_W-1:0]   invalid_pages;
        logic [STAMP_W-1:0] write_stamp;
        logic [ERASE_W-1:0] wear_count;
    } meta_t;

    typedef struct packed {
        logic start;
        logic step;
        logic fifo;
    } pick_ctrl_t;

    typedef struct packed {
        logic             found;
        logic [BLK_W-1:0] pick;
    } pick_res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RMW,
        S_SCAN,
        S_DONE,
        S_OUT
    } state_t;

endpackage

[rtl/gcvbs_pick.sv]
`timescale 1ns / 1ps
// gcvbs_pick: running victim comparator, one metadata entry per step.
// Depends on gcvbs_pkg.
module gcvbs_pick (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gcvbs_pkg::pick_ctrl_t     ctrl,
    input  gcvbs_pkg::meta_t          entry,
    input  logic [gcvbs_pkg::BLK_W-1:0] idx,
    input  logic [7:0]                hot,
    input  logic [7:0]                cold,
    output gcvbs_pkg::pick_res_t      res
);
    import gcvbs_pkg::*;

    logic               found_reg, found_next;
    logic [BLK_W-1:0]   pick_reg, pick_next;
    logic [CNT_W-1:0]   best_inv_reg, best_inv_next;
    logic [STAMP_W-1:0] best_stamp_reg, best_stamp_next;
    logic               eligible;
    logic               take;

    always_comb
    begin
        eligible = (idx != hot) && (idx != cold) && (entry.free_pages == '0);
        if (ctrl.fifo)
            take = eligible && (entry.invalid_pages != '0)
                   && (entry.write_stamp <= best_stamp_reg);
        else
            take = eligible && (!found_reg || (entry.invalid_pages > best_inv_reg));

        found_next      = found_reg;
        pick_next       = pick_reg;
        best_inv_next   = best_inv_reg;
        best_stamp_next = best_stamp_reg;
        if (ctrl.start)
        begin
            found_next      = 1'b0;
            pick_next       = '0;
            best_inv_next   = '0;
            best_stamp_next = FIFO_TIME_LIMIT;
        end
        else if (ctrl.step && take)
        begin
            found_next      = 1'b1;
            pick_next       = idx;
            best_inv_next   = entry.invalid_pages;
            best_stamp_next = entry.write_stamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            found_reg <= 1'b0;
        else
            found_reg <= found_next;
    end

    always_ff @(posedge clk)
    begin
        pick_reg       <= pick_next;
        best_inv_reg   <= best_inv_next;
        best_stamp_reg <= best_stamp_next;
    end

    assign res.found = found_reg;
    assign res.pick  = pick_reg;

endmodule

[rtl/gc_victim_block_selector.sv]
`timescale 1ns / 1ps
// gc_victim_block_selector: top level, per-block metadata RAM and op sequencer.
// Depends on gcvbs_pkg and gcvbs_pick.
// Write/erase: read-modify-write of one RAM entry through S_RMW, result loaded from S_OUT.
// Select: S_SCAN reads one RAM entry per cycle over all entries, then S_DONE and S_OUT.
// Unused op: straight to S_OUT with a zero result. One request in flight at a time; the next
// request is taken the cycle after the result is loaded.
// Reset: per-entry valid flops clear at once; unwritten entries read as zero.
module gc_victim_block_selector (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  gcvbs_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output gcvbs_pkg::rsp_t rsp,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [10:0]     cfg_data
);
    import gcvbs_pkg::*;

    meta_t              mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] valid_reg;
    meta_t              mem_q_reg;
    logic               valid_q_reg;
    meta_t              ent;

    state_t             state_reg, state_next;
    req_t               req_reg;
    rsp_t               res_reg, res_next;
    rsp_t               rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [BLK_W-1:0]   q_idx_reg, q_idx_next;
    logic               policy_mode_reg;
    logic [CNT_W-1:0]   pages_per_block_reg;

    logic               accept;
    logic               rd_en;
    logic [BLK_W-1:0]   rd_addr;
    logic               wr_en;
    meta_t              wr_data;
    logic [ERASE_W-1:0] erase_new;
    pick_ctrl_t         pick_ctrl;
    pick_res_t          pick_res;

    assign accept = req_valid && !req_stall;
    assign ent    = valid_q_reg ? mem_q_reg : '0;

    always_ff @(posedge clk)
    begin
        if (rd_en)
            mem_q_reg <= mem[rd_addr];
        if (wr_en)
            mem[req_reg.block_index] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            valid_q_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
                valid_q_reg <= valid_reg[rd_addr];
            if (wr_en)
                valid_reg[req_reg.block_index] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_mode_reg     <= POLICY_GREEDY;
            pages_per_block_reg <= 11'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POLICY_MODE:     policy_mode_reg     <= cfg_data[0];
                CFG_PAGES_PER_BLOCK: pages_per_block_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    gcvbs_pick u_pick (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (pick_ctrl),
        .entry (ent),
        .idx   (q_idx_reg),
        .hot   (req_reg.hot_active_block),
        .cold  (req_reg.cold_active_block_in),
        .res   (pick_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        rd_en          = 1'b0;
        rd_addr        = q_idx_reg + 1'b1;
        wr_en          = 1'b0;
        wr_data        = ent;
        res_next       = res_reg;
        q_idx_next     = q_idx_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        pick_ctrl      = '{start: 1'b0, step: 1'b0, fifo: policy_mode_reg};
        erase_new      = (ent.wear_count == '1) ? ent.wear_count
                                                : ent.wear_count + 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.op)
                        OP_WRITE, OP_ERASE:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = req.block_index;
                            state_next = S_RMW;
                        end
                        OP_SELECT:
                        begin
                            rd_en           = 1'b1;
                            rd_addr         = '0;
                            q_idx_next      = '0;
                            pick_ctrl.start = 1'b1;
                            state_next      = S_SCAN;
                        end
                        default:
                        begin
                            res_next   = '0;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_RMW:
            begin
                wr_en    = 1'b1;
                res_next = '0;
                if (req_reg.op == OP_ERASE)
                begin
                    wr_data.free_pages    = pages_per_block_reg;
                    wr_data.invalid_pages = '0;
                    wr_data.wear_count    = erase_new;
                    res_next.erase_total  = erase_new;
                end
                else
                begin
                    wr_data.free_pages    = req_reg.free_count_in;
                    wr_data.invalid_pages = req_reg.invalid_count_in;
                    wr_data.write_stamp   = req_reg.write_time_in;
                end
                state_next = S_OUT;
            end
            S_SCAN:
            begin
                pick_ctrl.step = 1'b1;
                rd_en          = 1'b1;
                q_idx_next     = q_idx_reg + 1'b1;
                if (q_idx_reg == LAST_BLOCK)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                res_next = '0;
                if (pick_res.found && (pages_per_block_reg != '0))
                    res_next.victim_block = 8'(pick_res.pick);
                else
                    res_next.status = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= req;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
        q_idx_reg <= q_idx_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_no_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status |-> rsp.victim_block == '0)
        else $error("victim reported with no-victim status");

    a_erase_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.erase_total != '0) |-> !rsp.status)
        else $error("erase result carries failure status");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("sequencer idle right after accepting a request");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && (q_idx_reg == LAST_BLOCK) |=> state_reg == S_DONE)
        else $error("scan did not end after last block");

    a_rmw_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RMW |=> valid_reg[$past(req_reg.block_index)])
        else $error("metadata entry not marked valid after write-back");

endmodule
